// ===== hw/rtl/pds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Types, widths and codes shared by the pairwise distance statistics unit.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int MAX_JOINTS     = 32;
  localparam int COORD_BITS     = 24;
  localparam int SET_COUNT_BITS = 20;

  localparam int JIDX_BITS  = $clog2(MAX_JOINTS);
  localparam int JCNT_BITS  = JIDX_BITS + 1;
  localparam int JC_BITS    = 7;
  localparam int PAIR_BITS  = 2 * JIDX_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int SUM_BITS   = DIST_BITS + SET_COUNT_BITS;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int ACC_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = ACC_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 3;
  localparam int STEP_BITS  = $clog2(SUM_BITS);
  localparam int JWORD_BITS = 3 * COORD_BITS;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic REG_JOINT_COUNT = 1'b0;
  localparam logic REG_TOTAL_SETS  = 1'b1;

  localparam logic [JC_BITS-1:0] JOINT_COUNT_RESET = JC_BITS'(MAX_JOINTS);

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [4:0]                   joint_index;
    logic [4:0]                   other_joint;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } req_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] min_dist;
    logic [DIST_BITS-1:0] mean_dist;
    logic [DIST_BITS-1:0] max_dist;
    logic                 no_data;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_JREAD, S_SQ, S_SQRT_INIT, S_SQRT, S_UPDATE,
    S_RD_MEM, S_DIV_INIT, S_DIV, S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR_STEP, OP_ACCEPT, OP_JREAD, OP_SQ, OP_SQRT_INIT, OP_SQRT,
    OP_UPDATE, OP_RD_MEM, OP_DIV_INIT, OP_DIV, OP_RESULT
  } op_t;

  typedef struct packed {
    logic sample_last;
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic pair_last;
    logic clr_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pds_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface pds_req_if;
  import pds_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pds_rsp_if;
  import pds_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pds_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: accepts items and steps the datapath through each operation.
// ----------------------------------------------------------------------------
module pds_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic [1:0]      req_type,
  input  wire pds_pkg::status_t status,
  output logic                 req_ready,
  output pds_pkg::op_t         op
);
  import pds_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        op = OP_CLR_STEP;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op = OP_ACCEPT;
          case (req_type)
            REQ_SAMPLE: if (status.sample_last) state_next = S_JREAD;
            REQ_READ:   state_next = S_RD_MEM;
            REQ_CLEAR:  state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_JREAD: begin
        op         = OP_JREAD;
        state_next = S_SQ;
      end
      S_SQ: begin
        op = OP_SQ;
        if (status.sq_done) state_next = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        op         = OP_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT;
        if (status.sqrt_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        op         = OP_UPDATE;
        state_next = status.pair_last ? S_IDLE : S_JREAD;
      end
      S_RD_MEM: begin
        op         = OP_RD_MEM;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        op         = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV;
        if (status.div_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          op         = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pds_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_datapath
// Joint and statistics memories, shared squarer, square root and divider.
// ----------------------------------------------------------------------------
module pds_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pds_pkg::op_t                    op,
  input  wire pds_pkg::req_item_t              req_data,
  input  wire logic [pds_pkg::JC_BITS-1:0]     joint_count,
  input  wire logic [pds_pkg::SET_COUNT_BITS-1:0] total_sets,
  input  wire logic                            rsp_ready,
  output logic                                 rsp_valid,
  output pds_pkg::rsp_item_t                   rsp_data,
  output pds_pkg::status_t                     status
);
  import pds_pkg::*;

  logic [JWORD_BITS-1:0] joint_mem [MAX_JOINTS];
  logic [DIST_BITS-1:0]  min_mem   [1 << PAIR_BITS];
  logic [DIST_BITS-1:0]  max_mem   [1 << PAIR_BITS];
  logic [SUM_BITS-1:0]   sum_mem   [1 << PAIR_BITS];

  logic [JWORD_BITS-1:0]     jw_a, jw_b;
  logic [DIST_BITS-1:0]      min_q, max_q;
  logic [SUM_BITS-1:0]       sum_q;
  logic [JIDX_BITS-1:0]      j, k, rd_a, rd_b;
  logic [PAIR_BITS-1:0]      clr_addr;
  logic [SET_COUNT_BITS-1:0] sets_seen;
  logic [1:0]                sq_cnt;
  logic [SQ_BITS-1:0]        prod;
  logic [ACC_BITS-1:0]       acc, sh;
  logic [REM_BITS-1:0]       rem;
  logic [ROOT_BITS-1:0]      root;
  logic [STEP_BITS-1:0]      step;
  logic [SUM_BITS-1:0]       dvd;
  logic [SET_COUNT_BITS-1:0] drem, dvs;
  logic                      rd_ok, rd_none;

  logic [JCNT_BITS-1:0]      n;
  logic [JIDX_BITS-1:0]      nm1;
  logic [PAIR_BITS-1:0]      pair_idx, rd_idx;
  logic signed [COORD_BITS-1:0] ca, cb;
  logic signed [DIFF_BITS-1:0]  diff;
  logic [DIFF_BITS-1:0]      mag;
  logic [REM_BITS-1:0]       rem_sh, trial;
  logic [SET_COUNT_BITS:0]   dtry;
  logic [DIST_BITS-1:0]      d, min_new, max_new, mean;
  logic [SUM_BITS:0]         sum_ext;
  logic [SUM_BITS-1:0]       sum_new;
  logic                      first;

  always_comb begin
    if (joint_count == '0) begin
      n = JCNT_BITS'(1);
    end else if (joint_count > JC_BITS'(MAX_JOINTS)) begin
      n = JCNT_BITS'(MAX_JOINTS);
    end else begin
      n = joint_count[JCNT_BITS-1:0];
    end
    nm1      = JIDX_BITS'(n - JCNT_BITS'(1));
    pair_idx = {j, k};
    rd_idx   = (op == OP_RD_MEM) ? {rd_a, rd_b} : pair_idx;
    case (sq_cnt)
      2'd0: begin
        ca = jw_a[3*COORD_BITS-1:2*COORD_BITS];
        cb = jw_b[3*COORD_BITS-1:2*COORD_BITS];
      end
      2'd1: begin
        ca = jw_a[2*COORD_BITS-1:COORD_BITS];
        cb = jw_b[2*COORD_BITS-1:COORD_BITS];
      end
      default: begin
        ca = jw_a[COORD_BITS-1:0];
        cb = jw_b[COORD_BITS-1:0];
      end
    endcase
    diff    = DIFF_BITS'(cb) - DIFF_BITS'(ca);
    mag     = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    rem_sh  = {rem[REM_BITS-3:0], sh[ACC_BITS-1 -: 2]};
    trial   = REM_BITS'({root, 2'b01});
    dtry    = {drem, dvd[SUM_BITS-1]};
    d       = root[DIST_BITS-1:0];
    first   = (sets_seen == '0);
    min_new = (first || d < min_q) ? d : min_q;
    max_new = (first || d > max_q) ? d : max_q;
    sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(d);
    sum_new = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    mean    = (dvd > SUM_BITS'({DIST_BITS{1'b1}})) ? '1 : dvd[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (op == OP_ACCEPT && req_data.req_type == REQ_SAMPLE) begin
      joint_mem[req_data.joint_index] <= {req_data.pos_x, req_data.pos_y, req_data.pos_z};
    end
    if (op == OP_JREAD) begin
      jw_a <= joint_mem[j];
      jw_b <= joint_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_JREAD || op == OP_RD_MEM) begin
      min_q <= min_mem[rd_idx];
      max_q <= max_mem[rd_idx];
      sum_q <= sum_mem[rd_idx];
    end
    if (op == OP_UPDATE) begin
      min_mem[pair_idx] <= min_new;
      max_mem[pair_idx] <= max_new;
      sum_mem[pair_idx] <= sum_new;
    end else if (op == OP_CLR_STEP) begin
      sum_mem[clr_addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      sets_seen <= '0;
      j         <= '0;
      k         <= '0;
      sq_cnt    <= '0;
      step      <= '0;
    end else begin
      case (op)
        OP_CLR_STEP: clr_addr <= clr_addr + PAIR_BITS'(1);
        OP_ACCEPT: begin
          j    <= '0;
          k    <= '0;
          rd_a <= req_data.joint_index;
          rd_b <= req_data.other_joint;
          if (req_data.req_type == REQ_CLEAR) begin
            clr_addr  <= '0;
            sets_seen <= '0;
          end
        end
        OP_JREAD: sq_cnt <= '0;
        OP_SQ: begin
          sq_cnt <= sq_cnt + 2'd1;
          prod   <= SQ_BITS'(mag) * SQ_BITS'(mag);
          acc    <= (sq_cnt == 2'd0) ? '0 : acc + ACC_BITS'(prod);
        end
        OP_SQRT_INIT: begin
          sh   <= acc;
          rem  <= '0;
          root <= '0;
          step <= '0;
        end
        OP_SQRT: begin
          sh   <= sh << 2;
          step <= step + STEP_BITS'(1);
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
        end
        OP_UPDATE: begin
          if (k == nm1) begin
            k <= '0;
            j <= j + JIDX_BITS'(1);
          end else begin
            k <= k + JIDX_BITS'(1);
          end
          if (j == nm1 && k == nm1 && sets_seen != '1) begin
            sets_seen <= sets_seen + SET_COUNT_BITS'(1);
          end
        end
        OP_RD_MEM: begin
          rd_none <= first;
          rd_ok   <= !first && (JCNT_BITS'(rd_a) < n) && (JCNT_BITS'(rd_b) < n);
        end
        OP_DIV_INIT: begin
          dvd  <= sum_q;
          drem <= '0;
          dvs  <= (total_sets == '0) ? SET_COUNT_BITS'(1) : total_sets;
          step <= '0;
        end
        OP_DIV: begin
          step <= step + STEP_BITS'(1);
          if (dtry >= (SET_COUNT_BITS + 1)'(dvs)) begin
            drem <= SET_COUNT_BITS'(dtry - (SET_COUNT_BITS + 1)'(dvs));
            dvd  <= {dvd[SUM_BITS-2:0], 1'b1};
          end else begin
            drem <= dtry[SET_COUNT_BITS-1:0];
            dvd  <= {dvd[SUM_BITS-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (op == OP_RESULT) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_RESULT) begin
      rsp_data.min_dist  <= rd_ok ? min_q : '0;
      rsp_data.max_dist  <= rd_ok ? max_q : '0;
      rsp_data.mean_dist <= rd_ok ? mean : '0;
      rsp_data.no_data   <= rd_none;
    end
  end

  always_comb begin
    status.sample_last = (req_data.req_type == REQ_SAMPLE) && (req_data.joint_index == nm1);
    status.sq_done     = (sq_cnt == 2'd3);
    status.sqrt_done   = (step == STEP_BITS'(ROOT_BITS - 1));
    status.div_done    = (step == STEP_BITS'(SUM_BITS - 1));
    status.pair_last   = (j == nm1) && (k == nm1);
    status.clr_done    = (clr_addr == '1);
    status.out_free    = !rsp_valid || rsp_ready;
  end

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.no_data) |->
    (rsp_data.min_dist == '0 && rsp_data.mean_dist == '0 && rsp_data.max_dist == '0))
    else $error("no_data result with nonzero statistics");

  a_sqrt_steps: assert property (@(posedge clk) disable iff (rst)
    (op == OP_SQRT) |-> (step < STEP_BITS'(ROOT_BITS)))
    else $error("square root ran past its step count");

  a_sets_seen: assert property (@(posedge clk) disable iff (rst)
    (sets_seen != $past(sets_seen)) |->
    (sets_seen == '0 || sets_seen == $past(sets_seen) + SET_COUNT_BITS'(1)))
    else $error("set count moved by other than one");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RESULT) |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over a pending item");

endmodule
`default_nettype wire

// ===== hw/rtl/pairwise_distance_stats_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_distance_stats_unit
// Per-pair joint distance minimum, maximum and mean over pose sets.
// ----------------------------------------------------------------------------
// Sample item: the last joint of a set starts a pass over all n*n joint pairs for n
//   joints (joint read, squarer, 26-step square root, update).
// Read item: statistics memory read and 45-step divider, then the result register.
// Clear item and reset: sweep of all 1024 sum memory entries, no items taken.
// One item at a time; a result waits in its output register.
// ----------------------------------------------------------------------------
module pairwise_distance_stats_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pds_req_if.sink                            req,
  pds_rsp_if.source                          rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pds_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [pds_pkg::DATA_BITS-1:0] pwdata,
  output logic [pds_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready
);
  import pds_pkg::*;

  logic [JC_BITS-1:0]        joint_count;
  logic [SET_COUNT_BITS-1:0] total_sets;
  op_t                       op;
  status_t                   status;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= JOINT_COUNT_RESET;
      total_sets  <= SET_COUNT_BITS'(1);
    end else if (wr_en) begin
      unique case (paddr[ADDR_BITS-1])
        REG_JOINT_COUNT: joint_count <= pwdata[JC_BITS-1:0];
        REG_TOTAL_SETS:  total_sets  <= pwdata[SET_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_BITS-1])
      REG_JOINT_COUNT: prdata = DATA_BITS'(joint_count);
      REG_TOTAL_SETS:  prdata = DATA_BITS'(total_sets);
      default:         prdata = '0;
    endcase
  end

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.data.req_type),
    .status    (status),
    .req_ready (req.ready),
    .op        (op)
  );

  pds_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .req_data    (req.data),
    .joint_count (joint_count),
    .total_sets  (total_sets),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_data    (rsp.data),
    .status      (status)
  );

endmodule
`default_nettype wire
